### rtl/fpmd_pkg.sv
// Shared types for the Q16.16 multiply/divide unit.
// Operation kinds and the item passed from the front end to the divider pipe.
package fpmd_pkg;

    typedef enum logic [1:0] {
        KIND_MUL_WIDE = 2'd0,
        KIND_DIV      = 2'd1,
        KIND_MUL_DIV  = 2'd2
    } kind_t;

    localparam int unsigned DIV_STEPS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES          = 64 / DIV_STEPS_PER_STAGE;

    // Numerator is the 64-bit dividend (or product for multiply wide).
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } fpmd_item_t;

endpackage

### rtl/fixed_point_mul_div_unit.sv
// Top level of the Q16.16 multiply/divide unit: front end, queue, divider pipe.
// Depends on fpmd_pkg, fpmd_front, fpmd_queue and fpmd_back.
//
//   channel | direction | tdata fields (low bit first)             | tuser fields
//   s_      | in        | op_a[31:0] op_b[63:32] op_c[95:64]        | kind[1:0]
//   m_      | out       | value[63:0]                               | divide_by_zero[0]
//
// One beat per cycle sustained while m_ accepts. From the s_ beat to m_tvalid the path is:
// the front register with the multiply, one queue slot, sign prep, 32 divider stages
// at two quotient bits each, and the output register. Reset clears all valid flags.
// A stall on m_ freezes the divider pipe; the queue and front register absorb
// three more beats before s_tready drops.
module fixed_point_mul_div_unit
    import fpmd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // op_a, op_b, op_c
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // value
    output logic         m_tuser    // divide_by_zero
);

    fpmd_item_t  fr_item;
    fpmd_item_t  q_item;
    logic        fr_valid;
    logic        fr_ready;
    logic        q_valid;
    logic        q_ready;
    logic [63:0] value;
    logic        dz;

    fpmd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_a      (s_tdata[31:0]),
        .in_b      (s_tdata[63:32]),
        .in_c      (s_tdata[95:64]),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    fpmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    fpmd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (value),
        .out_dz    (dz)
    );

    assign m_tdata = value;
    assign m_tuser = dz;

endmodule

### rtl/fpmd_front.sv
// Front end: accepts input beats, decodes the kind and forms dividend/divisor.
// Holds one registered multiply. Depends on fpmd_pkg.
module fpmd_front
    import fpmd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   in_kind,
    input  logic [31:0]  in_a,
    input  logic [31:0]  in_b,
    input  logic [31:0]  in_c,
    output logic         out_valid,
    input  logic         out_ready,
    output fpmd_item_t   out_item
);

    logic               valid_reg;
    fpmd_item_t         item_reg;
    fpmd_item_t         item_next;
    logic signed [63:0] product;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        product        = 64'(signed'(in_a)) * 64'(signed'(in_b));
        item_next.kind = in_kind;
        if (in_kind == KIND_DIV) begin
            item_next.num = {{16{in_a[31]}}, in_a, 16'd0};
            item_next.den = signed'(in_b);
        end else begin
            item_next.num = product;
            item_next.den = signed'(in_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/fpmd_queue.sv
// Two-entry queue between the front end and the divider pipe.
// Depends on fpmd_pkg for the item type.
module fpmd_queue
    import fpmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  fpmd_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output fpmd_item_t  out_item
);

    fpmd_item_t mem [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/fpmd_back.sv
// Back end: sign handling, pipelined restoring divider, result formatting.
// Two quotient bits per stage; depends on fpmd_pkg.
module fpmd_back
    import fpmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  fpmd_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_value,
    output logic        out_dz
);

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic        neg;
        logic        dz;
        logic [63:0] wide;
        logic [63:0] num;
        logic [31:0] rem;
        logic [31:0] den;
    } stage_t;

    stage_t      st_reg [DIV_STAGES + 1];
    stage_t      st_next [DIV_STAGES + 1];
    logic        en;
    logic        out_valid_reg;
    logic [63:0] out_value_reg;
    logic        out_dz_reg;
    logic [63:0] quot;
    logic [63:0] value_next;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_dz    = out_dz_reg;

    always_comb begin
        logic [32:0] r;
        logic [63:0] n;
        logic [31:0] rm;
        // prep stage: magnitudes, quotient sign, wide multiply result
        st_next[0].valid = in_valid;
        st_next[0].kind  = in_item.kind;
        st_next[0].neg   = in_item.num[63] ^ in_item.den[31];
        st_next[0].dz    = (in_item.kind == KIND_DIV || in_item.kind == KIND_MUL_DIV)
                           && in_item.den == 32'sd0;
        st_next[0].wide  = 64'((in_item.num + (in_item.num[63] ? 64'sd65535 : 64'sd0))
                           >>> 16);
        st_next[0].num   = in_item.num[63] ? 64'(-in_item.num) : 64'(in_item.num);
        st_next[0].rem   = 32'd0;
        st_next[0].den   = in_item.den[31] ? 32'(-in_item.den) : 32'(in_item.den);
        for (int s = 1; s <= DIV_STAGES; s++) begin
            st_next[s] = st_reg[s - 1];
            n  = st_reg[s - 1].num;
            rm = st_reg[s - 1].rem;
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                r = {rm, n[63]};
                n = {n[62:0], 1'b0};
                if (r >= {1'b0, st_reg[s - 1].den}) begin
                    r    = r - {1'b0, st_reg[s - 1].den};
                    n[0] = 1'b1;
                end
                rm = r[31:0];
            end
            if (st_reg[s - 1].kind == KIND_DIV || st_reg[s - 1].kind == KIND_MUL_DIV) begin
                st_next[s].num = n;
                st_next[s].rem = rm;
            end
        end
        quot = st_reg[DIV_STAGES].neg ? 64'(-st_reg[DIV_STAGES].num)
                                      : st_reg[DIV_STAGES].num;
        if (st_reg[DIV_STAGES].kind == KIND_MUL_WIDE) begin
            value_next = st_reg[DIV_STAGES].wide;
        end else if (st_reg[DIV_STAGES].kind == KIND_DIV
                     || st_reg[DIV_STAGES].kind == KIND_MUL_DIV) begin
            value_next = st_reg[DIV_STAGES].dz ? 64'd1 : {{32{quot[31]}}, quot[31:0]};
        end else begin
            value_next = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                st_reg[s].valid <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                st_reg[s].valid <= st_next[s].valid;
            end
            out_valid_reg <= st_reg[DIV_STAGES].valid;
        end
        if (en) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                st_reg[s].kind <= st_next[s].kind;
                st_reg[s].neg  <= st_next[s].neg;
                st_reg[s].dz   <= st_next[s].dz;
                st_reg[s].wide <= st_next[s].wide;
                st_reg[s].num  <= st_next[s].num;
                st_reg[s].rem  <= st_next[s].rem;
                st_reg[s].den  <= st_next[s].den;
            end
            out_value_reg <= value_next;
            out_dz_reg    <= st_reg[DIV_STAGES].dz;
        end
    end

endmodule

### bench/fixed_point_mul_div_unit_test.sv
// Testbench for the Q16.16 multiply/divide unit: random and directed beats on s_,
// results on m_ checked against a local predictor. Depends on fpmd_pkg and the RTL.
module fixed_point_mul_div_unit_test;
    import fpmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic [31:0] op_c;
    } operation_t;

    typedef struct {
        logic [63:0] value;
        logic        dz;
    } answer_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    operation_t pending_ops[$];
    answer_t    expected_answers[$];
    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_hold;
    bit  hold_request;
    bit  send_pause;
    int  quiet_cycles;

    fixed_point_mul_div_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic answer_t predict_answer(operation_t op);
        answer_t r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        logic signed [63:0] q;
        a = {{32{op.op_a[31]}}, op.op_a};
        b = {{32{op.op_b[31]}}, op.op_b};
        c = {{32{op.op_c[31]}}, op.op_c};
        r.value = '0;
        r.dz = 1'b0;
        case (op.kind)
            KIND_MUL_WIDE: begin
                r.value = (a * b) / 64'sd65536;
            end
            KIND_DIV: begin
                if (b == 0) begin
                    r.value = 64'd1;
                    r.dz = 1'b1;
                end else begin
                    q = (a * 64'sd65536) / b;
                    r.value = {{32{q[31]}}, q[31:0]};
                end
            end
            KIND_MUL_DIV: begin
                if (c == 0) begin
                    r.value = 64'd1;
                    r.dz = 1'b1;
                end else begin
                    q = (a * b) / c;
                    r.value = {{32{q[31]}}, q[31:0]};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 2) - 1;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            4: return $signed($urandom_range(0, 'h3ffff)) - 'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [1:0] kind, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        operation_t op;
        op.kind = kind;
        op.op_a = a;
        op.op_b = b;
        op.op_c = c;
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: offer the head of the queue, advance on a handshake.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(predict_answer(pending_ops.pop_front()));
            end
            if (pending_ops.size() > 0 && !send_pause
                && (s_tvalid && !s_tready || $urandom_range(0, 99) >= send_idle_pct)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_ops[0].op_c, pending_ops[0].op_b, pending_ops[0].op_a};
                s_tuser  <= pending_ops[0].kind;
            end else if (!(s_tvalid && !s_tready)) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        answer_t exp_ans;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result beat actual value=%h dz=%b",
                             $realtime, m_tdata, m_tuser);
                    errors++;
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (m_tdata !== exp_ans.value) begin
                        $display("%0t: value mismatch expected %h actual %h",
                                 $realtime, exp_ans.value, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== exp_ans.dz) begin
                        $display("%0t: divide_by_zero mismatch expected %b actual %b",
                                 $realtime, exp_ans.dz, m_tuser);
                        errors++;
                    end
                end
            end
            if (hold_request && recv_hold == 0) begin
                recv_hold <= 300;
                m_tready  <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: count cycles without any beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] corner_vals[6];
        int n;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        send_idle_pct = 31;
        recv_idle_pct = 75;
        hold_request = 1'b0;
        send_pause = 1'b0;
        quiet_cycles = 0;
        corner_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff,
                        32'h0001_0000};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, zero divisors, 32-bit wrap and the unused kind.
        queue_op(KIND_MUL_WIDE, 32'h8000_0000, 32'h8000_0000, 32'h0);
        queue_op(KIND_MUL_WIDE, 32'h7fff_ffff, 32'h8000_0000, 32'h5);
        queue_op(KIND_MUL_WIDE, 32'hffff_ffff, 32'h0000_0001, 32'h0);
        queue_op(KIND_MUL_WIDE, 32'h0001_8000, 32'hfffe_0000, 32'h0);
        queue_op(KIND_DIV, 32'h1234_5678, 32'h0, 32'h0);
        queue_op(KIND_DIV, 32'h8000_0000, 32'hffff_ffff, 32'h0);
        queue_op(KIND_DIV, 32'h7fff_ffff, 32'h0000_0001, 32'h0);
        queue_op(KIND_DIV, 32'hffff_fffd, 32'h0000_0002, 32'hffff_ffff);
        queue_op(KIND_DIV, 32'h0003_0000, 32'h0002_0000, 32'h0);
        queue_op(KIND_MUL_DIV, 32'h1, 32'h1, 32'h0);
        queue_op(KIND_MUL_DIV, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        queue_op(KIND_MUL_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1);
        queue_op(KIND_MUL_DIV, 32'hffff_fff9, 32'h0000_0003, 32'h0000_0002);
        queue_op(KIND_MUL_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        queue_op(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        queue_op(2'd3, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 6; i++)
            queue_op(2'(i % 3), corner_vals[i], corner_vals[5 - i], corner_vals[(i + 2) % 6]);
        wait_drained();

        // Hold the receiver off while the sender keeps offering.
        send_idle_pct = 0;
        for (int i = 0; i < 60; i++)
            queue_op(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        hold_request = 1'b1;
        while (recv_hold == 0) @(posedge aclk);
        hold_request = 1'b0;
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 31 : 0;
            for (int i = 0; i < 190; i++) begin
                n = $urandom_range(0, 19);
                queue_op(n == 0 ? 2'd3 : 2'($urandom_range(0, 2)), pick_operand(),
                         pick_operand(), pick_operand());
            end
            if (phase == 0) begin
                // Let the sender pause for a full drain in the middle of the phase.
                while (pending_ops.size() > 95) @(posedge aclk);
                send_pause = 1'b1;
                while (s_tvalid || expected_answers.size() != 0) @(posedge aclk);
                send_pause = 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
